@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the tdpt_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/tdpt_pkg.sv @@
package tdpt_pkg;

   // Default width of the tested value.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/trial_division_prime_test.sv @@
// Channel   Direction   Handshake              Payload
// req       in          req_valid/req_stall    req_value (signed, VALUE_WIDTH)
// rsp       out         rsp_valid/rsp_stall    rsp_is_prime (1 bit)
//
// Each trial divisor runs one quotient bit per cycle through a bit-serial
// restoring divider, then one bound and remainder check.
// A prime needs about sqrt(value) divisors; negatives, zero and one skip the divider.
// Reset is synchronous and clears the sequencer and the output valid.
// A new transaction is taken once the previous result sits in the output
// register, even while rsp_stall holds it there.
module trial_division_prime_test #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_prime
);
   import tdpt_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   value_ff, value_in;
   logic [VALUE_WIDTH-1:0]   div_ff, div_in;
   logic [VALUE_WIDTH-1:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     prime_ff, prime_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_prime_ff, rsp_prime_in;

   logic [VALUE_WIDTH:0]     trial;
   logic [VALUE_WIDTH:0]     diff;
   logic                     req_take;
   logic                     out_free;

   // Handshake decodes.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // One step of the restoring divider: shift in the next dividend bit.
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      prime_ff     <= prime_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      prime_in     = prime_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               value_in = req_value;
               div_in   = VALUE_WIDTH'(2);
               rem_in   = '0;
               quo_in   = req_value;
               cnt_in   = '0;
               prime_in = 1'b0;
               // Negative values, zero and one are never prime.
               if (req_value[VALUE_WIDTH-1] || (req_value < VALUE_WIDTH'(2))) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (!diff[VALUE_WIDTH]) begin
               rem_in = diff[VALUE_WIDTH-1:0];
            end else begin
               rem_in = trial[VALUE_WIDTH-1:0];
            end
            quo_in = {quo_ff[VALUE_WIDTH-2:0], !diff[VALUE_WIDTH]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Divisor above the quotient means divisor squared exceeds the value.
            if (div_ff > quo_ff) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else if (rem_ff == '0) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               div_in   = div_ff + 1'b1;
               rem_in   = '0;
               quo_in   = value_ff;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

endmodule

@@ rtl/core/tdpt_checker.sv @@
`include "assert_macros.svh"

module tdpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_is_prime
);

   // A held result stays offered and unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_is_prime))

   // The block works on one transaction at a time.
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

   // A result never appears in the cycle right after a transaction is taken.
   `ASSERT_SAME(a_no_instant_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && !req_stall))

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

@@ tb/trial_division_prime_test_checker.sv @@
`timescale 1ns / 1ps

module trial_division_prime_test_checker #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_is_prime,
   output int                            mismatch_count,
   output int                            results_due,
   output int                            values_tested,
   output int                            primes_seen
);

   // Primality flags of accepted values whose result has not arrived yet.
   bit prime_flags_due[$];

   // Running totals; an int starts at zero.
   int errors_so_far;
   int tested_so_far;
   int primes_so_far;

   // Trial division over the bit pattern: a set sign bit means a negative
   // value, and negatives, zero and one are never prime. The bound d <= n / d
   // is the exact integer form of d*d <= n.
   function automatic bit prime_by_trial_division(logic [VALUE_WIDTH-1:0] raw);
      longint unsigned n;
      longint unsigned d;
      if (raw[VALUE_WIDTH-1])
         return 1'b0;
      n = raw;
      if (n < 2)
         return 1'b0;
      for (d = 2; d <= n / d; d++) begin
         if (n % d == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Record the expected flag of every accepted value, then compare each
   // accepted result with the oldest flag still outstanding.
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         prime_flags_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            prime_flags_due.push_back(prime_by_trial_division(req_value));
            tested_so_far++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (prime_flags_due.size() == 0) begin
               $error("unexpected transaction: is_prime=%0b with no value outstanding",
                      rsp_is_prime);
               errors_so_far++;
            end else begin
               want = prime_flags_due.pop_front();
               if (rsp_is_prime !== want) begin
                  $error("field is_prime: expected %0b, actual %0b", want, rsp_is_prime);
                  errors_so_far++;
               end
               if (want)
                  primes_so_far++;
            end
         end
      end
      // Outputs are registered so the top always sees settled values.
      mismatch_count <= errors_so_far;
      results_due    <= prime_flags_due.size();
      values_tested  <= tested_so_far;
      primes_seen    <= primes_so_far;
   end

endmodule

@@ tb/trial_division_prime_test_tb.sv @@
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

   localparam int VALUE_WIDTH   = tdpt_pkg::VALUE_WIDTH_DEFAULT;
   localparam int QUIET_LIMIT   = 5_000_000;
   localparam int RANDOM_VALUES = 80;
   localparam int CALM_TAIL     = 15;
   localparam int DRAIN_CYCLES  = 40;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_is_prime;

   bit idling_on = 1'b1;
   int stall_left;
   int quiet_cycles;
   int mismatch_count;
   int results_due;
   int values_tested;
   int primes_seen;

   // Signed extremes, the values below two, small primes and composites,
   // squares of primes where d*d equals the value, and large words.
   int corner_values[$] = '{
      32'h8000_0000, -1, -7, 0, 1, 2, 3, 4, 5, 9, 25, 49, 97,
      1042441, 65536, 65537, 32'h5555_5555, 32'h2AAA_AAAA,
      32'hAAAA_AAAA, 32'h7FFF_FFFE, 32'h7FFF_FFFF
   };

   int odd_small_primes[5] = '{3, 5, 7, 11, 13};

   always #5 clock = ~clock;

   trial_division_prime_test #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   trial_division_prime_test_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_prime   (rsp_is_prime),
      .mismatch_count (mismatch_count),
      .results_due    (results_due),
      .values_tested  (values_tested),
      .primes_seen    (primes_seen)
   );

   // Result-side backpressure in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: too long without any transaction on either channel.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one value, optionally after a gap, and hold it until accepted.
   // Valid is only lowered when a gap starts, never between back-to-back values.
   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      int          sel;
      int unsigned word;
      int unsigned factor;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_values[i])
         send_value(corner_values[i]);

      // Mostly small operands keep the divisor search short; full-width words
      // are shaped to be negative or to carry a small factor.
      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n == RANDOM_VALUES - CALM_TAIL)
            idling_on = 1'b0;
         sel = $urandom_range(0, 9);
         case (sel)
            0, 1, 2, 3, 4: begin
               word = $urandom_range(0, 65535);
            end
            5: begin
               word = $urandom_range(0, (1 << 22) - 1);
            end
            6: begin
               word = $urandom();
               word[31] = 1'b1;
            end
            7, 8: begin
               word = $urandom();
               word[0] = 1'b0;
            end
            default: begin
               factor = odd_small_primes[$urandom_range(0, 4)];
               word = factor * $urandom_range(1, 32'h7FFF_FFFF / factor);
            end
         endcase
         send_value(word);
      end
      req_valid <= 1'b0;

      // Let every outstanding result arrive, then watch for stray ones.
      @(posedge clock);
      while (results_due != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d values, %0d of them prime: signed extremes, small and",
               values_tested, primes_seen);
      $display("medium operands, prime squares and full-width words under random stalls.");
      if (mismatch_count == 0 && results_due == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
